@@ design/expiry_min_heap_timer_queue_assert.svh @@
// Assertion macros for the timer queue RTL.
`ifndef EXPIRY_MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define EXPIRY_MIN_HEAP_TIMER_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EMHTQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EMHTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/emhtq_pkg.sv @@
// Package with shared types, codes and default sizes of the timer queue.
`default_nettype none
package emhtq_pkg;

  // Default sizes.
  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int ID_BITS_DEF   = 16;

  // Command codes carried on the input tuser.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t STATUS_ADDED   = 2'd0;
  localparam status_t STATUS_FULL    = 2'd1;
  localparam status_t STATUS_EXPIRED = 2'd2;
  localparam status_t STATUS_NONE    = 2'd3;

  // Control part of one result handed from the sequencer to the output stage.
  typedef struct packed {
    status_t status;
    logic    last;
  } res_ctl_t;

endpackage
`default_nettype wire

@@ design/emhtq_ram.sv @@
// Heap storage: one write port and two registered read ports.
`default_nettype none
module emhtq_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wa,
  input  wire logic [WIDTH-1:0]  wd,
  input  wire logic [ADDR_W-1:0] ra,
  input  wire logic [ADDR_W-1:0] rb,
  output logic      [WIDTH-1:0]  qa,
  output logic      [WIDTH-1:0]  qb
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; reads return the contents before a same-cycle write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule
`default_nettype wire

@@ design/emhtq_seq.sv @@
// Heap sequencer: sift-up on add, pop and sift-down on tick.
`default_nettype none
`include "expiry_min_heap_timer_queue_assert.svh"
module emhtq_seq #(
  parameter int CAPACITY  = emhtq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = emhtq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS   = emhtq_pkg::ID_BITS_DEF,
  localparam int ADDR_W   = $clog2(CAPACITY),
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Command side.
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_cmd,
  input  wire logic [TIME_BITS-1:0] in_expire,
  input  wire logic [ID_BITS-1:0]   in_conn,
  input  wire logic [TIME_BITS-1:0] in_now,
  // Result side.
  output logic                      emit_valid,
  input  wire logic                 emit_ready,
  output emhtq_pkg::res_ctl_t       emit_ctl,
  output logic [ID_BITS-1:0]        emit_conn,
  output logic [TIME_BITS-1:0]      emit_at,
  output logic [CNT_W-1:0]          emit_occ
);
  import emhtq_pkg::*;

  localparam int EW  = TIME_BITS + ID_BITS;
  localparam int AW1 = ADDR_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PLACE  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_TK_CHK = 3'd3;
  localparam logic [2:0] S_DN_CMP = 3'd4;
  localparam logic [2:0] S_DN_PUT = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic [EW-1:0]        key_r, key_nxt;
  logic [EW-1:0]        pop_r, pop_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] root_r, root_nxt;
  status_t              status_r, status_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra, mem_rb;
  logic [EW-1:0]     mem_wd, mem_qa, mem_qb;

  logic [ADDR_W-1:0]    par_of_count, par_of_pos, par_of_par, count_last;
  logic [TIME_BITS-1:0] key_new, key_a, key_b, key_best;
  logic [EW-1:0]        best_ent;
  logic [AW1-1:0]       right_idx, next_left, cnt_ext, cnt_dec_ext;
  logic [ADDR_W-1:0]    best_addr;
  logic                 right_ok, more;
  logic [CNT_W-1:0]     count_dec;

  emhtq_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (EW),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rb  (mem_rb),
    .qa  (mem_qa),
    .qb  (mem_qb)
  );

  // Index arithmetic of the heap.
  assign par_of_count = (ADDR_W'(count_r) - ADDR_W'(1)) >> 1;
  assign par_of_pos   = (pos_r - ADDR_W'(1)) >> 1;
  assign par_of_par   = (par_of_pos - ADDR_W'(1)) >> 1;
  assign count_last   = ADDR_W'(count_r - CNT_W'(1));
  assign count_dec    = count_r - CNT_W'(1);
  assign cnt_ext      = AW1'(count_r);
  assign cnt_dec_ext  = AW1'(count_dec);

  // Child compare: pick the smaller child, the left one on a tie.
  assign key_new   = key_r[EW-1 -: TIME_BITS];
  assign key_a     = mem_qa[EW-1 -: TIME_BITS];
  assign key_b     = mem_qb[EW-1 -: TIME_BITS];
  assign right_idx = {pos_r, 1'b0} + AW1'(2);
  assign right_ok  = (right_idx < cnt_ext) && (key_b < key_a);
  assign best_ent  = right_ok ? mem_qb : mem_qa;
  assign key_best  = best_ent[EW-1 -: TIME_BITS];
  assign best_addr = right_ok ? ADDR_W'(right_idx) : ADDR_W'(right_idx - AW1'(1));
  assign next_left = {best_addr, 1'b0} + AW1'(1);

  // Another pop follows when the new root is due too.
  assign more = (count_r != '0) && (root_r <= now_r);

  // Result fields.
  assign emit_ctl.status = status_r;
  assign emit_ctl.last   = !((status_r == STATUS_EXPIRED) && more);
  assign emit_conn       = (status_r == STATUS_EXPIRED) ? pop_r[ID_BITS-1:0] : '0;
  assign emit_at         = (status_r == STATUS_EXPIRED) ? pop_r[EW-1 -: TIME_BITS] : '0;
  assign emit_occ        = count_r;
  assign emit_valid      = (state_r == S_EMIT);
  assign in_ready        = (state_r == S_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    pop_nxt    = pop_r;
    now_nxt    = now_r;
    root_nxt   = root_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_wa     = pos_r;
    mem_wd     = key_r;
    mem_ra     = '0;
    mem_rb     = count_last;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_ADD) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = S_EMIT;
            end else begin
              key_nxt    = {in_expire, in_conn};
              pos_nxt    = ADDR_W'(count_r);
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = STATUS_ADDED;
              mem_ra     = par_of_count;
              state_nxt  = (count_r == '0) ? S_PLACE : S_UP_CMP;
            end
          end else begin
            now_nxt   = in_now;
            mem_ra    = '0;
            mem_rb    = count_last;
            state_nxt = S_TK_CHK;
          end
        end
      end
      S_UP_CMP: begin
        // Move the parent down while the new key is strictly earlier.
        if (key_new < key_a) begin
          mem_we  = 1'b1;
          mem_wa  = pos_r;
          mem_wd  = mem_qa;
          pos_nxt = par_of_pos;
          mem_ra  = par_of_par;
          if (par_of_pos == '0) begin
            state_nxt = S_PLACE;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_wa    = pos_r;
        mem_wd    = key_r;
        state_nxt = S_EMIT;
      end
      S_TK_CHK: begin
        // Pop the root if due; the last entry becomes the one to sink.
        if ((count_r != '0) && (key_a <= now_r)) begin
          pop_nxt    = mem_qa;
          key_nxt    = mem_qb;
          count_nxt  = count_dec;
          pos_nxt    = '0;
          status_nxt = STATUS_EXPIRED;
          mem_ra     = ADDR_W'(1);
          mem_rb     = ADDR_W'(2);
          if (count_dec == '0) begin
            state_nxt = S_EMIT;
          end else if (cnt_dec_ext > AW1'(1)) begin
            state_nxt = S_DN_CMP;
          end else begin
            state_nxt = S_DN_PUT;
          end
        end else begin
          status_nxt = STATUS_NONE;
          state_nxt  = S_EMIT;
        end
      end
      S_DN_CMP: begin
        // Lift the smaller child while it is strictly earlier.
        mem_we = 1'b1;
        mem_wa = pos_r;
        if (key_best < key_new) begin
          mem_wd  = best_ent;
          pos_nxt = best_addr;
          mem_ra  = ADDR_W'(next_left);
          mem_rb  = ADDR_W'(next_left + AW1'(1));
          if (pos_r == '0) begin
            root_nxt = key_best;
          end
          state_nxt = (next_left < cnt_ext) ? S_DN_CMP : S_DN_PUT;
        end else begin
          mem_wd = key_r;
          if (pos_r == '0) begin
            root_nxt = key_new;
          end
          state_nxt = S_EMIT;
        end
      end
      S_DN_PUT: begin
        mem_we = 1'b1;
        mem_wa = pos_r;
        mem_wd = key_r;
        if (pos_r == '0) begin
          root_nxt = key_new;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ready) begin
          mem_ra    = '0;
          mem_rb    = count_last;
          state_nxt = ((status_r == STATUS_EXPIRED) && more) ? S_TK_CHK : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    pop_r    <= pop_nxt;
    now_r    <= now_nxt;
    root_r   <= root_nxt;
    status_r <= status_nxt;
  end

  `EMHTQ_ASSERT_SAME(a_count_range, 1'b1, count_r <= CNT_W'(CAPACITY), "occupancy above capacity")
  `EMHTQ_ASSERT_SAME(a_write_in_heap, mem_we, AW1'(mem_wa) < cnt_ext, "write beyond heap end")
  `EMHTQ_ASSERT_SAME(a_full_only_at_cap, emit_valid && (status_r == STATUS_FULL), count_r == CNT_W'(CAPACITY), "full reported below capacity")
  `EMHTQ_ASSERT_SAME(a_more_only_expired, emit_valid && !emit_ctl.last, status_r == STATUS_EXPIRED, "non-final result that is not an expiry")
  `EMHTQ_ASSERT_NEXT(a_pop_follows, emit_valid && emit_ready && !emit_ctl.last, state_r == S_TK_CHK, "pop chain broken")

endmodule
`default_nettype wire

@@ design/expiry_min_heap_timer_queue.sv @@
// Add: accept, then a compare step for each level climbed, then place and emit.
// Tick: for each expired entry, check, then a sink step for each level sunk, then emit.
// A tick with nothing due goes through check and emit; one item is worked at a time.
// Each level step compares keys read from the heap RAM through its registered read ports.
// Synchronous active-low reset empties the heap at once; entry contents need no clearing.
// Top level: stream ports, output register and the heap sequencer.
`default_nettype none
module expiry_min_heap_timer_queue #(
  parameter int CAPACITY   = emhtq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS  = emhtq_pkg::TIME_BITS_DEF,
  parameter int ID_BITS    = emhtq_pkg::ID_BITS_DEF,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IN_DATA_W = ((2 * TIME_BITS + ID_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((TIME_BITS + ID_BITS + CNT_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // expire_time, conn_id, now_time
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // expired_conn, expired_at, occupancy
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status
  output emhtq_pkg::status_t         out_tuser,
  output logic                       out_tlast
);
  import emhtq_pkg::*;

  logic                 emit_valid, emit_ready;
  res_ctl_t             emit_ctl;
  logic [ID_BITS-1:0]   emit_conn;
  logic [TIME_BITS-1:0] emit_at;
  logic [CNT_W-1:0]     emit_occ;

  logic                 out_valid_r;
  res_ctl_t             out_ctl_r;
  logic [ID_BITS-1:0]   out_conn_r;
  logic [TIME_BITS-1:0] out_at_r;
  logic [CNT_W-1:0]     out_occ_r;

  emhtq_seq #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_expire  (in_tdata[TIME_BITS-1:0]),
    .in_conn    (in_tdata[TIME_BITS +: ID_BITS]),
    .in_now     (in_tdata[TIME_BITS + ID_BITS +: TIME_BITS]),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_ctl   (emit_ctl),
    .emit_conn  (emit_conn),
    .emit_at    (emit_at),
    .emit_occ   (emit_occ)
  );

  // The output register takes a new result when empty or being drained.
  assign emit_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      out_ctl_r  <= emit_ctl;
      out_conn_r <= emit_conn;
      out_at_r   <= emit_at;
      out_occ_r  <= emit_occ;
    end
  end

  // Result transfer fields.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ctl_r.status;
  assign out_tlast  = out_ctl_r.last;
  assign out_tdata  = OUT_DATA_W'({out_occ_r, out_at_r, out_conn_r});

endmodule
`default_nettype wire
